// ----- src/bbo_pkg.sv -----
// ----------------------------------------------------------------------------
// bbo_pkg
// Shared types, codes and reset values of the box outline overlay.
// ----------------------------------------------------------------------------
package bbo_pkg;

	localparam int MAX_POINTS_DEF  = 16;
	localparam int COORD_BITS_DEF  = 12;
	localparam int GROUP_SIZE      = 16;

	localparam int DIM_W     = 13;
	localparam int HALF_W    = 8;
	localparam int CHAN_W    = 8;
	localparam int ACT_W     = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PIXEL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_BLUE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_GREEN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_RED     = 3'd6;

	localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [HALF_W-1:0] RST_HALF_WIDTH   = 8'd5;
	localparam logic [HALF_W-1:0] RST_HALF_HEIGHT  = 8'd5;
	localparam logic [CHAN_W-1:0] RST_MARK_BLUE    = 8'd0;
	localparam logic [CHAN_W-1:0] RST_MARK_GREEN   = 8'd255;
	localparam logic [CHAN_W-1:0] RST_MARK_RED     = 8'd0;

	typedef struct packed {
		logic [DIM_W-1:0]  image_width;
		logic [DIM_W-1:0]  image_height;
		logic [HALF_W-1:0] half_width;
		logic [HALF_W-1:0] half_height;
		logic [CHAN_W-1:0] mark_blue;
		logic [CHAN_W-1:0] mark_green;
		logic [CHAN_W-1:0] mark_red;
	} cfg_t;

endpackage

// ----- src/bbo_in_if.sv -----
// ----------------------------------------------------------------------------
// bbo_in_if
// Input channel: clear, add and pixel transactions.
// ----------------------------------------------------------------------------
interface bbo_in_if #(
	parameter int COORD_BITS = 12
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [COORD_BITS-1:0] col;
	logic [COORD_BITS-1:0] row;
	logic [7:0]            grey;

	modport source (output valid, action, col, row, grey, input ready);
	modport sink   (input valid, action, col, row, grey, output ready);
endinterface

// ----- src/bbo_out_if.sv -----
// ----------------------------------------------------------------------------
// bbo_out_if
// Output channel: one BGR pixel transaction per input pixel.
// ----------------------------------------------------------------------------
interface bbo_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic       marked;

	modport source (output valid, out_blue, out_green, out_red, marked, input ready);
	modport sink   (input valid, out_blue, out_green, out_red, marked, output ready);
endinterface

// ----- src/bounding_box_overlay.sv -----
// ----------------------------------------------------------------------------
// bounding_box_overlay
// Pipeline: five registered stages (s1..s5) from input transaction to output pixel.
// Throughput: one transaction per cycle unless the output stalls; clear/add update the table at s1->s2.
// Stalls on the output hold every full stage; nothing is dropped or repeated.
// Reset: point table empty, configuration at its reset values, pipeline empty.
// ----------------------------------------------------------------------------
module bounding_box_overlay #(
	parameter int MAX_POINTS = bbo_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bbo_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bbo_pkg::CFG_DATA_W-1:0] wr_data,
	bbo_in_if.sink                         pix_in,
	bbo_out_if.source                      pix_out
);
	import bbo_pkg::*;

	cfg_t                  cfg;
	logic                  v_s1;
	logic [ACT_W-1:0]      action_s1;
	logic [COORD_BITS-1:0] col_s1, row_s1;
	logic [CHAN_W-1:0]     grey_s1;
	logic                  ready_s1, match_ready;
	logic                  hit_valid, hit_ready;
	logic [MAX_POINTS-1:0] hit_lanes;
	logic [CHAN_W-1:0]     hit_grey;

	assign ready_s1     = !v_s1 || match_ready;
	assign pix_in.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			action_s1 <= pix_in.action;
			col_s1    <= pix_in.col;
			row_s1    <= pix_in.row;
			grey_s1   <= pix_in.grey;
		end
	end

	bbo_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bbo_point_match #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (v_s1),
		.in_ready  (match_ready),
		.in_action (action_s1),
		.in_col    (col_s1),
		.in_row    (row_s1),
		.in_grey   (grey_s1),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit_lanes (hit_lanes),
		.hit_grey  (hit_grey)
	);

	bbo_hit_reduce #(
		.MAX_POINTS (MAX_POINTS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.hit_valid (hit_valid),
		.hit_ready (hit_ready),
		.hit_lanes (hit_lanes),
		.hit_grey  (hit_grey),
		.pix_out   (pix_out)
	);

endmodule

// ----- src/bbo_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bbo_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module bbo_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bbo_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bbo_pkg::CFG_DATA_W-1:0] wr_data,
	output bbo_pkg::cfg_t                  cfg
);
	import bbo_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.half_width   <= RST_HALF_WIDTH;
			cfg_q.half_height  <= RST_HALF_HEIGHT;
			cfg_q.mark_blue    <= RST_MARK_BLUE;
			cfg_q.mark_green   <= RST_MARK_GREEN;
			cfg_q.mark_red     <= RST_MARK_RED;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= wr_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= wr_data[DIM_W-1:0];
				REG_HALF_WIDTH:   cfg_q.half_width   <= wr_data[HALF_W-1:0];
				REG_HALF_HEIGHT:  cfg_q.half_height  <= wr_data[HALF_W-1:0];
				REG_MARK_BLUE:    cfg_q.mark_blue    <= wr_data[CHAN_W-1:0];
				REG_MARK_GREEN:   cfg_q.mark_green   <= wr_data[CHAN_W-1:0];
				REG_MARK_RED:     cfg_q.mark_red     <= wr_data[CHAN_W-1:0];
				default:          ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/bbo_point_match.sv -----
// ----------------------------------------------------------------------------
// bbo_point_match
// Point table and per-point compare lanes: offsets (s2), border hits (s3).
// ----------------------------------------------------------------------------
module bbo_point_match #(
	parameter int MAX_POINTS = bbo_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = bbo_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bbo_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bbo_pkg::ACT_W-1:0]   in_action,
	input  logic [COORD_BITS-1:0]       in_col,
	input  logic [COORD_BITS-1:0]       in_row,
	input  logic [bbo_pkg::CHAN_W-1:0]  in_grey,
	output logic                        hit_valid,
	input  logic                        hit_ready,
	output logic [MAX_POINTS-1:0]       hit_lanes,
	output logic [bbo_pkg::CHAN_W-1:0]  hit_grey
);
	import bbo_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CMP_W = (COORD_BITS > HALF_W) ? COORD_BITS : HALF_W;
	localparam int BND_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;

	logic [COORD_BITS-1:0] xs_q [MAX_POINTS];
	logic [COORD_BITS-1:0] ys_q [MAX_POINTS];
	logic [CNT_W-1:0]      count_q;

	logic                  v_s2;
	logic [COORD_BITS-1:0] dx_s2 [MAX_POINTS];
	logic [COORD_BITS-1:0] dy_s2 [MAX_POINTS];
	logic [MAX_POINTS-1:0] en_s2;
	logic                  in_image_s2;
	logic [CHAN_W-1:0]     grey_s2;

	logic                  v_s3;
	logic [MAX_POINTS-1:0] hit_s3;
	logic [CHAN_W-1:0]     grey_s3;

	logic ready_s2, ready_s3, take;
	logic in_image;

	assign ready_s3 = !v_s3 || hit_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign in_ready = ready_s2;
	assign take     = in_valid && ready_s2;
	assign in_image = (BND_W'(in_col) < BND_W'(cfg.image_width)) &&
	                  (BND_W'(in_row) < BND_W'(cfg.image_height));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take) begin
			if (in_action == ACT_CLEAR) begin
				count_q <= '0;
			end else if (in_action == ACT_ADD && count_q < CNT_W'(MAX_POINTS)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_action == ACT_ADD && count_q < CNT_W'(MAX_POINTS)) begin
			xs_q[count_q[IDX_W-1:0]] <= in_col;
			ys_q[count_q[IDX_W-1:0]] <= in_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s2) v_s2 <= in_valid && in_action == ACT_PIXEL;
			if (ready_s3) v_s3 <= v_s2;
		end
	end

	genvar k;
	generate
		for (k = 0; k < MAX_POINTS; k++) begin : g_lane
			always_ff @(posedge clk) begin
				if (ready_s2) begin
					dx_s2[k] <= (in_col >= xs_q[k]) ? in_col - xs_q[k] : xs_q[k] - in_col;
					dy_s2[k] <= (in_row >= ys_q[k]) ? in_row - ys_q[k] : ys_q[k] - in_row;
					en_s2[k] <= CNT_W'(k) < count_q;
				end
				if (ready_s3) begin
					hit_s3[k] <= en_s2[k] && in_image_s2 &&
					             CMP_W'(dx_s2[k]) <= CMP_W'(cfg.half_width) &&
					             CMP_W'(dy_s2[k]) <= CMP_W'(cfg.half_height) &&
					             (CMP_W'(dx_s2[k]) == CMP_W'(cfg.half_width) ||
					              CMP_W'(dy_s2[k]) == CMP_W'(cfg.half_height));
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			in_image_s2 <= in_image;
			grey_s2     <= in_grey;
		end
		if (ready_s3) begin
			grey_s3 <= grey_s2;
		end
	end

	assign hit_valid = v_s3;
	assign hit_lanes = hit_s3;
	assign hit_grey  = grey_s3;

endmodule

// ----- src/bbo_hit_reduce.sv -----
// ----------------------------------------------------------------------------
// bbo_hit_reduce
// OR tree over lane hits (s4 groups, s5 final) and output pixel select.
// ----------------------------------------------------------------------------
module bbo_hit_reduce #(
	parameter int MAX_POINTS = bbo_pkg::MAX_POINTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bbo_pkg::cfg_t              cfg,
	input  logic                       hit_valid,
	output logic                       hit_ready,
	input  logic [MAX_POINTS-1:0]      hit_lanes,
	input  logic [bbo_pkg::CHAN_W-1:0] hit_grey,
	bbo_out_if.source                  pix_out
);
	import bbo_pkg::*;

	localparam int NGROUPS = (MAX_POINTS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_W   = NGROUPS * GROUP_SIZE;

	logic [PAD_W-1:0]   lanes_pad;
	logic               v_s4;
	logic [NGROUPS-1:0] grp_s4;
	logic [CHAN_W-1:0]  grey_s4;
	logic               v_s5;
	logic               marked_s5;
	logic [CHAN_W-1:0]  blue_s5, green_s5, red_s5;
	logic               ready_s4, ready_s5;

	assign ready_s5  = !v_s5 || pix_out.ready;
	assign ready_s4  = !v_s4 || ready_s5;
	assign hit_ready = ready_s4;
	assign lanes_pad = PAD_W'(hit_lanes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ready_s4) v_s4 <= hit_valid;
			if (ready_s5) v_s5 <= v_s4;
		end
	end

	genvar g;
	generate
		for (g = 0; g < NGROUPS; g++) begin : g_grp
			always_ff @(posedge clk) begin
				if (ready_s4) grp_s4[g] <= |lanes_pad[g*GROUP_SIZE +: GROUP_SIZE];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (ready_s4) grey_s4 <= hit_grey;
		if (ready_s5) begin
			marked_s5 <= |grp_s4;
			blue_s5   <= (|grp_s4) ? cfg.mark_blue  : grey_s4;
			green_s5  <= (|grp_s4) ? cfg.mark_green : grey_s4;
			red_s5    <= (|grp_s4) ? cfg.mark_red   : grey_s4;
		end
	end

	assign pix_out.valid     = v_s5;
	assign pix_out.marked    = marked_s5;
	assign pix_out.out_blue  = blue_s5;
	assign pix_out.out_green = green_s5;
	assign pix_out.out_red   = red_s5;

endmodule
